// ----- rtl/core/pea_pkg.sv -----
// Package for the pointer event accumulator: evdev codes, widths,
// register indexes and the control structs between core modules.
// No dependencies.
`timescale 1ns / 1ps

package pea_pkg;

    // fixed-point fraction of the normalised touchpad position
    localparam int FRAC_BITS = 16;
    localparam int NORM_W    = FRAC_BITS + 1;   // 1.0 is representable
    localparam int POS_W     = 16;
    localparam int GAIN_W    = 12;
    localparam int ACC_W     = 16;
    localparam int VAL_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int PROD_W    = GAIN_W + NORM_W + 2;

    // evdev types
    localparam logic [15:0] EVT_KEY = 16'd1;
    localparam logic [15:0] EVT_REL = 16'd2;
    localparam logic [15:0] EVT_ABS = 16'd3;

    // evdev codes
    localparam logic [15:0] KEY_LEFT   = 16'h0110;
    localparam logic [15:0] KEY_RIGHT  = 16'h0111;
    localparam logic [15:0] KEY_MIDDLE = 16'h0112;
    localparam logic [15:0] KEY_TOUCH  = 16'h014A;
    localparam logic [15:0] AXIS_X     = 16'd0;
    localparam logic [15:0] AXIS_Y     = 16'd1;
    localparam logic [15:0] REL_HW     = 16'd6;
    localparam logic [15:0] REL_VW     = 16'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 3'd4;

    // divider handshake
    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] dividend;   // clamped offset from minimum
        logic [POS_W-1:0] divisor;    // range, nonzero
    } div_ctrl_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [NORM_W-1:0] quot;
    } div_stat_t;

endpackage

// ----- rtl/core/pointer_event_accumulator_top.sv -----
// Pointer event accumulator, top level: event decode, state, sequencer
// and output register. Depends on pea_pkg, pea_divider and pea_motion.
//
// Usage:
//  - Input channel (s_*, valid/ready) carries one evdev-style event or a
//    frame start per beat. Output channel (m_*, valid/ready) returns one
//    beat per input beat: the motion, button and wheel state after it.
//  - cfg_we/cfg_index/cfg_wdata write the touchpad limits and gain; write
//    only while the block is idle. Unknown indexes are ignored.
//  - Steps: keys, relative events, frame starts and ignored events go from
//    accept through prepare to output (an absolute touchpad event with an
//    empty or inverted range adds multiply and apply). Absolute touchpad
//    events with a valid range first run the serial divider, one quotient
//    bit a cycle, FRAC_BITS+1 of them, then multiply and apply.
//  - One item at a time: s_ready is high only when the sequencer is idle,
//    so the next beat waits until the last result is loaded for output.
//  - The output register parts the two sides: a new beat is accepted while
//    a result waits; a stalled receiver holds the sequencer at its last
//    step until the waiting result is taken.
//  - Reset (aresetn low, synchronous) clears the sequencer and pointer state,
//    restores register defaults and empties the output register.
`timescale 1ns / 1ps

module pointer_event_accumulator_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_we,
    input  logic [pea_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pea_pkg::CFG_DAT_W-1:0]      cfg_wdata,
    // input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_mode,
    input  logic                               s_source_kind,
    input  logic [15:0]                        s_event_type,
    input  logic [15:0]                        s_event_code,
    input  logic signed [pea_pkg::VAL_W-1:0]   s_event_value,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [pea_pkg::ACC_W-1:0]   m_motion_x,
    output logic signed [pea_pkg::ACC_W-1:0]   m_motion_y,
    output logic                               m_button_left,
    output logic                               m_button_right,
    output logic                               m_button_middle,
    output logic                               m_wheel_up,
    output logic                               m_wheel_down,
    output logic                               m_hwheel_up,
    output logic                               m_hwheel_down
);
    import pea_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PREP  = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_APPLY = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic signed [POS_W-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic [GAIN_W-1:0]       gain_reg;

    // latched beat
    logic                    mode_reg, src_reg;
    logic [15:0]             type_reg, code_reg;
    logic signed [VAL_W-1:0] val_reg;

    // block state
    logic [ACC_W-1:0]  acc_x_reg, acc_x_next;
    logic [ACC_W-1:0]  acc_y_reg, acc_y_next;
    logic [2:0]        btn_reg, btn_next;     // left, right, middle
    logic [3:0]        wheel_reg, wheel_next; // up, down, h up, h down
    logic              held_reg, held_next;
    logic [NORM_W-1:0] last_x_reg, last_x_next;
    logic [NORM_W-1:0] last_y_reg, last_y_next;
    logic              scx_reg, scx_next;
    logic              scy_reg, scy_next;
    logic [NORM_W-1:0] norm_reg, norm_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic [ACC_W-1:0] o_x_reg, o_y_reg;
    logic [2:0]       o_btn_reg;
    logic [3:0]       o_wheel_reg;

    div_ctrl_t        div_ctrl;
    div_stat_t        div_stat;
    logic [ACC_W-1:0] delta;

    // decode of the latched beat
    logic                    is_abs_x, is_abs_y, is_abs;
    logic signed [POS_W-1:0] lo, hi, pos_c;
    logic signed [POS_W:0]   range;
    logic [POS_W-1:0]        offset;
    logic                    val_nz, val_p1, val_m1, out_load;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        is_abs_x = !mode_reg && src_reg && type_reg == EVT_ABS && code_reg == AXIS_X;
        is_abs_y = !mode_reg && src_reg && type_reg == EVT_ABS && code_reg == AXIS_Y;
        is_abs   = is_abs_x || is_abs_y;
        lo       = is_abs_y ? y_min_reg : x_min_reg;
        hi       = is_abs_y ? y_max_reg : x_max_reg;
        range    = 17'(hi) - 17'(lo);
        // clamp the 32-bit position into [lo, hi]
        if (val_reg < VAL_W'(lo)) begin
            pos_c = lo;
        end else if (val_reg > VAL_W'(hi)) begin
            pos_c = hi;
        end else begin
            pos_c = val_reg[POS_W-1:0];
        end
        offset = pos_c - lo;
        val_nz = (val_reg != '0);
        val_p1 = (val_reg == VAL_W'(1));
        val_m1 = (val_reg == VAL_W'(-1));
    end

    pea_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .stat    (div_stat)
    );

    pea_motion u_motion (
        .aclk      (aclk),
        .capture   (state_reg == ST_MUL),
        .gain      (gain_reg),
        .norm      (norm_reg),
        .last_norm (is_abs_y ? last_y_reg : last_x_reg),
        .delta     (delta)
    );

    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next  = state_reg;
        acc_x_next  = acc_x_reg;
        acc_y_next  = acc_y_reg;
        btn_next    = btn_reg;
        wheel_next  = wheel_reg;
        held_next   = held_reg;
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        scx_next    = scx_reg;
        scy_next    = scy_reg;
        norm_next   = norm_reg;
        div_ctrl.start    = 1'b0;
        div_ctrl.dividend = offset;
        div_ctrl.divisor  = range[POS_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = ST_OUT;
                if (mode_reg) begin
                    // frame start
                    acc_x_next = '0;
                    acc_y_next = '0;
                    wheel_next = '0;
                end else if (is_abs) begin
                    if (range > 17'sd0) begin
                        div_ctrl.start = 1'b1;
                        state_next     = ST_DIV;
                    end else begin
                        // empty or inverted range normalises to zero
                        norm_next  = '0;
                        state_next = ST_MUL;
                    end
                end else if (!src_reg) begin
                    if (type_reg == EVT_KEY) begin
                        case (code_reg)
                            KEY_LEFT:   btn_next[0] = val_nz;
                            KEY_RIGHT:  btn_next[1] = val_nz;
                            KEY_MIDDLE: btn_next[2] = val_nz;
                            default:    ;
                        endcase
                    end else if (type_reg == EVT_REL) begin
                        case (code_reg)
                            AXIS_X: acc_x_next = acc_x_reg + val_reg[ACC_W-1:0];
                            AXIS_Y: acc_y_next = acc_y_reg + val_reg[ACC_W-1:0];
                            REL_VW: begin
                                if (val_p1) wheel_next[0] = 1'b1;
                                if (val_m1) wheel_next[1] = 1'b1;
                            end
                            REL_HW: begin
                                if (val_p1) wheel_next[2] = 1'b1;
                                if (val_m1) wheel_next[3] = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end else if (type_reg == EVT_KEY && code_reg == KEY_TOUCH) begin
                    // touch level; next X and Y only set the reference
                    held_next = val_nz;
                    scx_next  = 1'b0;
                    scy_next  = 1'b0;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    norm_next  = div_stat.quot;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (is_abs_y) begin
                    if (held_reg && scy_reg) acc_y_next = acc_y_reg + delta;
                    last_y_next = norm_reg;
                    scy_next    = 1'b1;
                end else begin
                    if (held_reg && scx_reg) acc_x_next = acc_x_reg + delta;
                    last_x_next = norm_reg;
                    scx_next    = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            x_min_reg   <= 16'sd0;
            x_max_reg   <= 16'sd4095;
            y_min_reg   <= 16'sd0;
            y_max_reg   <= 16'sd4095;
            gain_reg    <= 12'd500;
            acc_x_reg   <= '0;
            acc_y_reg   <= '0;
            btn_reg     <= '0;
            wheel_reg   <= '0;
            held_reg    <= 1'b0;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
            scx_reg     <= 1'b0;
            scy_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            acc_x_reg   <= acc_x_next;
            acc_y_reg   <= acc_y_next;
            btn_reg     <= btn_next;
            wheel_reg   <= wheel_next;
            held_reg    <= held_next;
            last_x_reg  <= last_x_next;
            last_y_reg  <= last_y_next;
            scx_reg     <= scx_next;
            scy_reg     <= scy_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_X_MIN: x_min_reg <= cfg_wdata;
                    CFG_X_MAX: x_max_reg <= cfg_wdata;
                    CFG_Y_MIN: y_min_reg <= cfg_wdata;
                    CFG_Y_MAX: y_max_reg <= cfg_wdata;
                    CFG_GAIN:  gain_reg  <= cfg_wdata[GAIN_W-1:0];
                    default:   ;
                endcase
            end
        end
        norm_reg <= norm_next;
        if (s_valid && s_ready) begin
            mode_reg <= s_mode;
            src_reg  <= s_source_kind;
            type_reg <= s_event_type;
            code_reg <= s_event_code;
            val_reg  <= s_event_value;
        end
        if (out_load) begin
            o_x_reg     <= acc_x_reg;
            o_y_reg     <= acc_y_reg;
            o_btn_reg   <= btn_reg;
            o_wheel_reg <= wheel_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_motion_x      = o_x_reg;
    assign m_motion_y      = o_y_reg;
    assign m_button_left   = o_btn_reg[0];
    assign m_button_right  = o_btn_reg[1];
    assign m_button_middle = o_btn_reg[2];
    assign m_wheel_up      = o_wheel_reg[0];
    assign m_wheel_down    = o_wheel_reg[1];
    assign m_hwheel_up     = o_wheel_reg[2];
    assign m_hwheel_down   = o_wheel_reg[3];

endmodule

// ----- rtl/core/pea_divider.sv -----
// Restoring divider: offset * 2^FRAC_BITS / range, one quotient bit a cycle
// through a single shared subtract-and-compare. Depends on pea_pkg.
`timescale 1ns / 1ps

module pea_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  pea_pkg::div_ctrl_t ctrl,
    output pea_pkg::div_stat_t stat
);
    import pea_pkg::*;

    localparam int CNT_W = $clog2(NORM_W + 1);

    logic [POS_W:0]    rem_reg, rem_next;
    logic [POS_W-1:0]  dvs_reg, dvs_next;
    logic [NORM_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              first_reg, first_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [POS_W:0]    trial;
    logic [POS_W+1:0]  diff;
    logic              ge;

    // first step compares the offset itself, later steps shift in a zero
    always_comb begin
        trial = first_reg ? rem_reg : {rem_reg[POS_W-1:0], 1'b0};
        diff  = {1'b0, trial} - {2'b00, dvs_reg};
        ge    = ~diff[POS_W+1];
    end

    always_comb begin
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (ctrl.start) begin
            rem_next   = {1'b0, ctrl.dividend};
            dvs_next   = ctrl.divisor;
            quot_next  = '0;
            cnt_next   = CNT_W'(NORM_W);
            first_next = 1'b1;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            rem_next   = {1'b0, (ge ? diff[POS_W-1:0] : trial[POS_W-1:0])};
            quot_next  = {quot_reg[NORM_W-2:0], ge};
            first_next = 1'b0;
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        quot_reg  <= quot_next;
        first_reg <= first_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.quot = quot_reg;

endmodule

// ----- rtl/core/pea_motion.sv -----
// Touchpad motion: registered gain * (norm - last_norm), then rounding half
// away from zero to a 16-bit wrapping delta. Depends on pea_pkg.
`timescale 1ns / 1ps

module pea_motion (
    input  logic                        aclk,
    input  logic                        capture,
    input  logic [pea_pkg::GAIN_W-1:0]  gain,
    input  logic [pea_pkg::NORM_W-1:0]  norm,
    input  logic [pea_pkg::NORM_W-1:0]  last_norm,
    output logic [pea_pkg::ACC_W-1:0]   delta
);
    import pea_pkg::*;

    localparam logic [PROD_W:0] RND_HALF = {{PROD_W{1'b0}}, 1'b1} << (FRAC_BITS - 1);

    logic signed [NORM_W:0]   step;
    logic signed [PROD_W-1:0] gain_s, step_s;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [PROD_W-1:0]        mag;
    logic [PROD_W:0]          rnd;
    logic [PROD_W+ACC_W:0]    rnd_ext;
    logic [ACC_W-1:0]         mag16;

    // both operands widened to the product width before the multiply
    always_comb begin
        step      = $signed({1'b0, norm}) - $signed({1'b0, last_norm});
        gain_s    = PROD_W'($signed({1'b0, gain}));
        step_s    = PROD_W'(step);
        prod_next = gain_s * step_s;
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            prod_reg <= prod_next;
        end
    end

    always_comb begin
        mag     = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        rnd     = {1'b0, mag} + RND_HALF;
        rnd_ext = {{ACC_W{1'b0}}, rnd} >> FRAC_BITS;
        mag16   = rnd_ext[ACC_W-1:0];
        delta   = prod_reg[PROD_W-1] ? ACC_W'(-mag16) : mag16;
    end

endmodule

// ----- tb/pointer_event_accumulator_checker.sv -----
`timescale 1ns / 1ps

// Result checker for the pointer event accumulator: follows config writes
// and event beats, keeps its own pointer state and compares every result beat.
// Depends on pea_pkg.
module pointer_event_accumulator_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [pea_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pea_pkg::CFG_DAT_W-1:0]       cfg_wdata,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_mode,
    input  logic                                s_source_kind,
    input  logic [15:0]                         s_event_type,
    input  logic [15:0]                         s_event_code,
    input  logic signed [pea_pkg::VAL_W-1:0]    s_event_value,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [pea_pkg::ACC_W-1:0]    m_motion_x,
    input  logic signed [pea_pkg::ACC_W-1:0]    m_motion_y,
    input  logic                                m_button_left,
    input  logic                                m_button_right,
    input  logic                                m_button_middle,
    input  logic                                m_wheel_up,
    input  logic                                m_wheel_down,
    input  logic                                m_hwheel_up,
    input  logic                                m_hwheel_down,
    output int                                  fail_count,
    output int                                  pending_reports
);
    import pea_pkg::*;

    typedef struct packed {
        logic [ACC_W-1:0] motion_x;
        logic [ACC_W-1:0] motion_y;
        logic             button_left;
        logic             button_right;
        logic             button_middle;
        logic             wheel_up;
        logic             wheel_down;
        logic             hwheel_up;
        logic             hwheel_down;
    } pointer_report_t;

    pointer_report_t   expected_reports[$];
    pointer_report_t   want;

    // touchpad limits and gain as last written
    int                x_lo, x_hi, y_lo, y_hi;
    logic [GAIN_W-1:0] gain;

    // pointer state
    logic [ACC_W-1:0]  acc_x, acc_y;
    logic [2:0]        buttons;       // left, right, middle
    logic [3:0]        wheels;        // up, down, h-up, h-down
    logic              touch_down;
    logic              x_tracking, y_tracking;
    logic [NORM_W-1:0] x_ref, y_ref;

    function automatic logic [NORM_W-1:0] touch_fraction(longint pos, int lo, int hi);
        longint span, p;
        span = longint'(hi) - longint'(lo);
        if (span <= 0)
            return '0;
        p = pos;
        if (p < lo) p = lo;
        if (p > hi) p = hi;
        return NORM_W'(((p - lo) << FRAC_BITS) / span);
    endfunction

    // gain times the change in fraction, rounded half away from zero
    function automatic logic [ACC_W-1:0] touch_delta(logic [NORM_W-1:0] now,
                                                      logic [NORM_W-1:0] prev);
        longint prod, mag, rounded;
        logic [ACC_W-1:0] d;
        prod    = longint'(gain) * (longint'(now) - longint'(prev));
        mag     = (prod < 0) ? -prod : prod;
        rounded = (mag + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        d       = rounded[ACC_W-1:0];
        if (prod < 0)
            d = -d;
        return d;
    endfunction

    task automatic track_pointer_event(input logic mode, input logic src,
                                       input logic [15:0] etype, input logic [15:0] ecode,
                                       input logic [31:0] evalue);
        longint            value;
        int                wbit;
        logic [NORM_W-1:0] now;
        value = longint'($signed(evalue));
        if (mode) begin
            acc_x  = '0;
            acc_y  = '0;
            wheels = '0;
        end else if (!src) begin
            if (etype == EVT_KEY) begin
                if (ecode == KEY_LEFT)        buttons[0] = (evalue != 0);
                else if (ecode == KEY_RIGHT)  buttons[1] = (evalue != 0);
                else if (ecode == KEY_MIDDLE) buttons[2] = (evalue != 0);
            end else if (etype == EVT_REL) begin
                if (ecode == AXIS_X)
                    acc_x = acc_x + evalue[ACC_W-1:0];
                else if (ecode == AXIS_Y)
                    acc_y = acc_y + evalue[ACC_W-1:0];
                else if (ecode == REL_VW || ecode == REL_HW) begin
                    wbit = (ecode == REL_VW) ? 0 : 2;
                    if (evalue == 32'd1)
                        wheels[wbit] = 1'b1;
                    else if (evalue == 32'hFFFF_FFFF)
                        wheels[wbit + 1] = 1'b1;
                end
            end
        end else begin
            if (etype == EVT_ABS && ecode == AXIS_X) begin
                now = touch_fraction(value, x_lo, x_hi);
                if (touch_down && x_tracking)
                    acc_x = acc_x + touch_delta(now, x_ref);
                x_ref      = now;
                x_tracking = 1'b1;
            end else if (etype == EVT_ABS && ecode == AXIS_Y) begin
                now = touch_fraction(value, y_lo, y_hi);
                if (touch_down && y_tracking)
                    acc_y = acc_y + touch_delta(now, y_ref);
                y_ref      = now;
                y_tracking = 1'b1;
            end else if (etype == EVT_KEY && ecode == KEY_TOUCH) begin
                touch_down = (evalue != 0);
                x_tracking = 1'b0;
                y_tracking = 1'b0;
            end
        end
        expected_reports.push_back('{acc_x, acc_y, buttons[0], buttons[1], buttons[2],
                                     wheels[0], wheels[1], wheels[2], wheels[3]});
    endtask

    task automatic check_field(input string field, input int expected_val, input int actual_val);
        if (expected_val != actual_val) begin
            $error("%s: expected %0d, actual %0d", field, expected_val, actual_val);
            fail_count++;
        end
    endtask

    initial begin
        fail_count      = 0;
        pending_reports = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            x_lo = 0;
            x_hi = 4095;
            y_lo = 0;
            y_hi = 4095;
            gain = GAIN_W'(500);
            acc_x      = '0;
            acc_y      = '0;
            buttons    = '0;
            wheels     = '0;
            touch_down = 1'b0;
            x_tracking = 1'b0;
            y_tracking = 1'b0;
            x_ref      = '0;
            y_ref      = '0;
            expected_reports.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_X_MIN: x_lo = int'($signed(cfg_wdata));
                    CFG_X_MAX: x_hi = int'($signed(cfg_wdata));
                    CFG_Y_MIN: y_lo = int'($signed(cfg_wdata));
                    CFG_Y_MAX: y_hi = int'($signed(cfg_wdata));
                    CFG_GAIN:  gain = cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            // result beat first: it can never belong to an event taken this edge
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("motion_x", $signed(want.motion_x), $signed(m_motion_x));
                    check_field("motion_y", $signed(want.motion_y), $signed(m_motion_y));
                    check_field("button_left", want.button_left, m_button_left);
                    check_field("button_right", want.button_right, m_button_right);
                    check_field("button_middle", want.button_middle, m_button_middle);
                    check_field("wheel_up", want.wheel_up, m_wheel_up);
                    check_field("wheel_down", want.wheel_down, m_wheel_down);
                    check_field("hwheel_up", want.hwheel_up, m_hwheel_up);
                    check_field("hwheel_down", want.hwheel_down, m_hwheel_down);
                end
            end
            if (s_valid && s_ready)
                track_pointer_event(s_mode, s_source_kind, s_event_type, s_event_code,
                                    s_event_value);
        end
        pending_reports = expected_reports.size();
    end

endmodule

// ----- tb/pointer_event_accumulator_top_tb.sv -----
`timescale 1ns / 1ps

// Testbench top for the pointer event accumulator: event beats, register
// writes, result back-pressure and the verdict.
// Depends on pea_pkg, pointer_event_accumulator_top and the checker.
module pointer_event_accumulator_top_tb;
    import pea_pkg::*;

    localparam int IDLE_PCT      = 29;        // chance per cycle that a side idles
    localparam int HOLD_CYCLES   = 300;       // receiver hold-off to fill the block
    localparam int SETTLE_CYCLES = 30;        // beyond the longest latency
    localparam int RUN_LIMIT_NS  = 5_000_000;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DAT_W-1:0]   cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_mode;
    logic                   s_source_kind;
    logic [15:0]            s_event_type;
    logic [15:0]            s_event_code;
    logic signed [VAL_W-1:0] s_event_value;
    logic                   m_valid;
    logic                   m_ready;
    logic signed [ACC_W-1:0] m_motion_x;
    logic signed [ACC_W-1:0] m_motion_y;
    logic                   m_button_left;
    logic                   m_button_right;
    logic                   m_button_middle;
    logic                   m_wheel_up;
    logic                   m_wheel_down;
    logic                   m_hwheel_up;
    logic                   m_hwheel_down;

    int fail_count;
    int pending_reports;

    // stimulus control: steady switches off idling on both sides,
    // squeeze asks the receiver for its long hold-off (once)
    bit steady;
    bit squeeze;
    int beats_offered;

    // touchpad limits as last written, used to aim positions near the range
    int range_x_lo, range_x_hi, range_y_lo, range_y_hi;

    pointer_event_accumulator_top DUT (.*);

    pointer_event_accumulator_checker report_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL pointer_event_accumulator_top");
        $finish;
    end

    // Result side: random stalls, none in steady stretches, and one long
    // hold-off counted here so the block backs up onto its input.
    initial begin : receiver
        int hold_left;
        bit squeeze_seen;
        hold_left    = 0;
        squeeze_seen = 1'b0;
        m_ready      = 1'b0;
        forever begin
            @(negedge aclk);
            if (squeeze && !squeeze_seen) begin
                squeeze_seen = 1'b1;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // One event beat: optional idle cycles first, then valid held until taken.
    task automatic offer(input logic mode, input logic src, input logic [15:0] etype,
                         input logic [15:0] ecode, input logic [31:0] evalue);
        @(negedge aclk);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_source_kind <= src;
        s_event_type  <= etype;
        s_event_code  <= ecode;
        s_event_value <= evalue;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        beats_offered++;
    endtask

    // Drop valid and wait until every result is back and the sequencer is idle.
    task automatic wait_drained;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_reports != 0 || !s_ready)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic retune(input int xl, input int xh, input int yl, input int yh,
                          input logic [CFG_DAT_W-1:0] gain_word);
        wait_drained;
        write_reg(CFG_X_MIN, CFG_DAT_W'(xl));
        write_reg(CFG_X_MAX, CFG_DAT_W'(xh));
        write_reg(CFG_Y_MIN, CFG_DAT_W'(yl));
        write_reg(CFG_Y_MAX, CFG_DAT_W'(yh));
        write_reg(CFG_GAIN, gain_word);
        range_x_lo = xl;
        range_x_hi = xh;
        range_y_lo = yl;
        range_y_hi = yh;
    endtask

    // Mostly just around the configured range (so clamping is hit on both
    // sides), sometimes any 32-bit position.
    function automatic logic [31:0] touch_point(input bit on_y);
        int a, b, lo, hi;
        lo = on_y ? range_y_lo : range_x_lo;
        hi = on_y ? range_y_hi : range_x_hi;
        a  = (lo < hi) ? lo : hi;
        b  = (lo < hi) ? hi : lo;
        if ($urandom_range(9) == 0)
            return $urandom;
        return 32'(a - 64 + int'($urandom_range(b - a + 128)));
    endfunction

    function automatic int upper_limit(input int lo);
        int hi;
        if ($urandom_range(4) == 0)
            return int'($urandom_range(65535)) - 32768;   // any, possibly inverted
        hi = lo + int'($urandom_range(3000));
        return (hi > 32767) ? 32767 : hi;
    endfunction

    // Random traffic: touch strokes (touch, positions, release) carry most
    // of the weight, then mouse activity, frame starts and plain noise.
    task automatic random_traffic(input int count);
        int          stop_at, steps, pick;
        bit          axis_y;
        logic [15:0] code;
        logic [31:0] amount;
        stop_at = beats_offered + count;
        while (beats_offered < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                offer(1'b0, 1'b1, EVT_KEY, KEY_TOUCH,
                      $urandom_range(1) ? 32'd1 : ($urandom | 32'd1));
                steps = $urandom_range(8, 1);
                repeat (steps) begin
                    axis_y = 1'($urandom_range(1));
                    offer(1'b0, 1'b1, EVT_ABS, axis_y ? AXIS_Y : AXIS_X, touch_point(axis_y));
                end
                if ($urandom_range(3) != 0)
                    offer(1'b0, 1'b1, EVT_KEY, KEY_TOUCH, 32'd0);
            end else if (pick < 65) begin
                case ($urandom_range(2))
                    0: begin
                        case ($urandom_range(2))
                            0:       code = KEY_LEFT;
                            1:       code = KEY_RIGHT;
                            default: code = KEY_MIDDLE;
                        endcase
                        case ($urandom_range(2))
                            0:       amount = 32'd0;
                            1:       amount = 32'd1;
                            default: amount = $urandom;
                        endcase
                        offer(1'b0, 1'b0, EVT_KEY, code, amount);
                    end
                    1: begin
                        amount = ($urandom_range(7) == 0) ? $urandom
                                                          : 32'($urandom_range(400)) - 32'd200;
                        offer(1'b0, 1'b0, EVT_REL, $urandom_range(1) ? AXIS_Y : AXIS_X, amount);
                    end
                    default: begin
                        case ($urandom_range(4))
                            0:       amount = 32'd1;
                            1:       amount = 32'hFFFF_FFFF;
                            2:       amount = 32'd0;
                            3:       amount = 32'd2;
                            default: amount = $urandom;
                        endcase
                        offer(1'b0, 1'b0, EVT_REL, $urandom_range(1) ? REL_HW : REL_VW, amount);
                    end
                endcase
            end else if (pick < 78) begin
                // frame start: other fields are junk
                offer(1'b1, 1'($urandom), 16'($urandom), 16'($urandom), $urandom);
            end else begin
                offer(1'b0, 1'($urandom),
                      $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(EVT_ABS)),
                      $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(KEY_TOUCH)),
                      $urandom);
            end
        end
    endtask

    initial begin : stimulus
        int idx, xl, yl;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_mode        = 1'b0;
        s_source_kind = 1'b0;
        s_event_type  = '0;
        s_event_code  = '0;
        s_event_value = '0;
        steady        = 1'b0;
        squeeze       = 1'b0;
        beats_offered = 0;
        range_x_lo    = 0;
        range_x_hi    = 4095;
        range_y_lo    = 0;
        range_y_hi    = 4095;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed pass on the reset limits and gain.
        // Buttons: set, extreme nonzero levels, release.
        offer(1'b0, 1'b0, EVT_KEY, KEY_LEFT,   32'd1);
        offer(1'b0, 1'b0, EVT_KEY, KEY_RIGHT,  32'h8000_0000);
        offer(1'b0, 1'b0, EVT_KEY, KEY_MIDDLE, 32'h7FFF_FFFF);
        offer(1'b0, 1'b0, EVT_KEY, KEY_LEFT,   32'd0);
        // Relative motion: only the low 16 bits count, accumulators wrap
        offer(1'b0, 1'b0, EVT_REL, AXIS_X, 32'd32767);
        offer(1'b0, 1'b0, EVT_REL, AXIS_X, 32'h7FFF_FFFF);
        offer(1'b0, 1'b0, EVT_REL, AXIS_Y, 32'hFFFF_8000);
        // All four wheel flags, then a frame start with junk fields clears them
        offer(1'b0, 1'b0, EVT_REL, REL_VW, 32'd1);
        offer(1'b0, 1'b0, EVT_REL, REL_VW, 32'hFFFF_FFFF);
        offer(1'b0, 1'b0, EVT_REL, REL_HW, 32'd1);
        offer(1'b0, 1'b0, EVT_REL, REL_HW, 32'hFFFF_FFFF);
        offer(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        // Ignored: wheel step other than one, unknown type, events the mouse
        // does not handle
        offer(1'b0, 1'b0, EVT_REL, REL_VW, 32'd2);
        offer(1'b0, 1'b0, 16'hFFFF, AXIS_X, 32'd5);
        offer(1'b0, 1'b0, EVT_ABS, AXIS_X, 32'd100);
        offer(1'b0, 1'b0, EVT_KEY, KEY_TOUCH, 32'd1);
        // Touchpad: position before touch, touch resets the reference,
        // clamping at both ends, negative motion, release
        offer(1'b0, 1'b1, EVT_ABS, AXIS_X, 32'h8000_0000);
        offer(1'b0, 1'b1, EVT_KEY, KEY_TOUCH, 32'd1);
        offer(1'b0, 1'b1, EVT_ABS, AXIS_X, 32'd2000);
        offer(1'b0, 1'b1, EVT_ABS, AXIS_Y, 32'h7FFF_FFFF);
        offer(1'b0, 1'b1, EVT_ABS, AXIS_X, 32'd4095);
        offer(1'b0, 1'b1, EVT_ABS, AXIS_Y, 32'd0);
        offer(1'b0, 1'b1, EVT_REL, AXIS_X, 32'd50);
        offer(1'b0, 1'b1, EVT_KEY, KEY_LEFT, 32'd1);
        offer(1'b0, 1'b1, EVT_KEY, KEY_TOUCH, 32'd0);
        offer(1'b0, 1'b1, EVT_ABS, AXIS_X, 32'd100);

        random_traffic(90);

        // Full-width X, inverted Y (fraction stuck at zero), maximum gain
        // written with the upper data bits set. No idling in this stretch.
        retune(-32768, 32767, 32767, -32768, 16'hFFFF);
        steady = 1'b1;
        random_traffic(110);
        steady = 1'b0;

        // Empty X range, tiny Y range, zero gain
        retune(100, 100, -5, 5, 16'h0000);
        random_traffic(60);

        // Two-count X range, full Y range, maximum gain; the receiver holds
        // off for a long stretch while beats keep coming
        retune(0, 1, -32768, 32767, 16'h0FFF);
        squeeze = 1'b1;
        random_traffic(100);

        // Random limits and gain, plus writes to the unused indexes
        repeat (2) begin
            xl = int'($urandom_range(65535)) - 32768;
            yl = int'($urandom_range(65535)) - 32768;
            retune(xl, upper_limit(xl), yl, upper_limit(yl), 16'($urandom));
            for (idx = CFG_GAIN + 1; idx < (1 << CFG_IDX_W); idx++)
                write_reg(CFG_IDX_W'(idx), 16'($urandom));
            random_traffic(60);
        end

        wait_drained;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_reports == 0)
            $display("PASS pointer_event_accumulator_top");
        else
            $display("FAIL pointer_event_accumulator_top");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/pea_pkg.sv
rtl/core/pea_divider.sv
rtl/core/pea_motion.sv
rtl/core/pointer_event_accumulator_top.sv
tb/pointer_event_accumulator_checker.sv
tb/pointer_event_accumulator_top_tb.sv
